@@ sv/tgje_pkg.sv @@
// Shared constants for the triangle gradient jump error block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package tgje_pkg;

	// Default width of one signed fixed-point input value.
	localparam int VALUE_BITS_DEF = 24;

	// The edge sum is divided by this factor before the square root is taken.
	localparam int DIV_FACTOR = 3;

	// Number of edges of a triangle.
	localparam int NUM_EDGES = 3;

endpackage

@@ sv/tgje_in_if.sv @@
// Input channel of the error block: one triangle (positions and gradients) per beat.
// Depends on tgje_pkg for the default value width.
interface tgje_in_if #(
	parameter int VALUE_BITS = tgje_pkg::VALUE_BITS_DEF
);
	logic valid;
	logic ready;
	logic signed [VALUE_BITS-1:0] ax;
	logic signed [VALUE_BITS-1:0] ay;
	logic signed [VALUE_BITS-1:0] bx;
	logic signed [VALUE_BITS-1:0] by_coord;
	logic signed [VALUE_BITS-1:0] cx;
	logic signed [VALUE_BITS-1:0] cy;
	logic signed [VALUE_BITS-1:0] ga_x;
	logic signed [VALUE_BITS-1:0] ga_y;
	logic signed [VALUE_BITS-1:0] gb_x;
	logic signed [VALUE_BITS-1:0] gb_y;
	logic signed [VALUE_BITS-1:0] gc_x;
	logic signed [VALUE_BITS-1:0] gc_y;

	modport source (
		output valid, ax, ay, bx, by_coord, cx, cy, ga_x, ga_y, gb_x, gb_y, gc_x, gc_y,
		input ready
	);

	modport sink (
		input valid, ax, ay, bx, by_coord, cx, cy, ga_x, ga_y, gb_x, gb_y, gc_x, gc_y,
		output ready
	);
endinterface

@@ sv/tgje_out_if.sv @@
// Output channel of the error block: one unsigned error estimate per beat.
// Depends on tgje_pkg for the default value width.
interface tgje_out_if #(
	parameter int VALUE_BITS = tgje_pkg::VALUE_BITS_DEF
);
	logic valid;
	logic ready;
	logic [VALUE_BITS:0] element_error;

	modport source (
		output valid, element_error,
		input ready
	);

	modport sink (
		input valid, element_error,
		output ready
	);
endinterface

@@ sv/tgje_front.sv @@
// Front pipeline: edge vectors, gradient differences, dot products, magnitudes and their sum.
// Depends on tgje_pkg; five register stages, all advanced by one common enable.
module tgje_front #(
	parameter int VALUE_BITS = tgje_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid,
	input  logic signed [VALUE_BITS-1:0] ax,
	input  logic signed [VALUE_BITS-1:0] ay,
	input  logic signed [VALUE_BITS-1:0] bx,
	input  logic signed [VALUE_BITS-1:0] by_coord,
	input  logic signed [VALUE_BITS-1:0] cx,
	input  logic signed [VALUE_BITS-1:0] cy,
	input  logic signed [VALUE_BITS-1:0] ga_x,
	input  logic signed [VALUE_BITS-1:0] ga_y,
	input  logic signed [VALUE_BITS-1:0] gb_x,
	input  logic signed [VALUE_BITS-1:0] gb_y,
	input  logic signed [VALUE_BITS-1:0] gc_x,
	input  logic signed [VALUE_BITS-1:0] gc_y,
	output logic                         sum_valid,
	output logic [2*VALUE_BITS+2:0]      sum
);
	localparam int NE = tgje_pkg::NUM_EDGES;
	localparam int DW = VALUE_BITS + 1;
	localparam int PW = 2 * VALUE_BITS + 2;
	localparam int AW = 2 * VALUE_BITS + 1;
	localparam int SW = 2 * VALUE_BITS + 3;

	logic signed [VALUE_BITS-1:0] pos_x [NE];
	logic signed [VALUE_BITS-1:0] pos_y [NE];
	logic signed [VALUE_BITS-1:0] grad_x [NE];
	logic signed [VALUE_BITS-1:0] grad_y [NE];

	logic signed [DW-1:0] ex_s1 [NE];
	logic signed [DW-1:0] ey_s1 [NE];
	logic signed [DW-1:0] gx_s1 [NE];
	logic signed [DW-1:0] gy_s1 [NE];
	logic signed [PW-1:0] px_s2 [NE];
	logic signed [PW-1:0] py_s2 [NE];
	logic signed [PW-1:0] dot_s3 [NE];
	logic [PW-1:0]        neg [NE];
	logic [AW-1:0]        mag_s4 [NE];
	logic [SW-1:0]        sum_s5;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign pos_x[0]  = ax;
	assign pos_x[1]  = bx;
	assign pos_x[2]  = cx;
	assign pos_y[0]  = ay;
	assign pos_y[1]  = by_coord;
	assign pos_y[2]  = cy;
	assign grad_x[0] = ga_x;
	assign grad_x[1] = gb_x;
	assign grad_x[2] = gc_x;
	assign grad_y[0] = ga_y;
	assign grad_y[1] = gb_y;
	assign grad_y[2] = gc_y;

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			neg[e] = -dot_s3[e];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Edge e runs from vertex e to the next vertex, wrapping from the last back to the first.
	// The sign of the dot product does not matter, since only its magnitude is kept.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NE; e++) begin
				ex_s1[e] <= {pos_x[(e == NE - 1) ? 0 : e + 1][VALUE_BITS-1],
					pos_x[(e == NE - 1) ? 0 : e + 1]} - {pos_x[e][VALUE_BITS-1], pos_x[e]};
				ey_s1[e] <= {pos_y[(e == NE - 1) ? 0 : e + 1][VALUE_BITS-1],
					pos_y[(e == NE - 1) ? 0 : e + 1]} - {pos_y[e][VALUE_BITS-1], pos_y[e]};
				gx_s1[e] <= {grad_x[(e == NE - 1) ? 0 : e + 1][VALUE_BITS-1],
					grad_x[(e == NE - 1) ? 0 : e + 1]} - {grad_x[e][VALUE_BITS-1], grad_x[e]};
				gy_s1[e] <= {grad_y[(e == NE - 1) ? 0 : e + 1][VALUE_BITS-1],
					grad_y[(e == NE - 1) ? 0 : e + 1]} - {grad_y[e][VALUE_BITS-1], grad_y[e]};
				px_s2[e] <= ex_s1[e] * gx_s1[e];
				py_s2[e] <= ey_s1[e] * gy_s1[e];
				dot_s3[e] <= px_s2[e] + py_s2[e];
				mag_s4[e] <= dot_s3[e][PW-1] ? neg[e][AW-1:0] : dot_s3[e][AW-1:0];
			end
			sum_s5 <= SW'(mag_s4[0]) + SW'(mag_s4[1]) + SW'(mag_s4[2]);
		end
	end

	assign sum_valid = vld_s5;
	assign sum       = sum_s5;

endmodule

@@ sv/tgje_sqrt_cell.sv @@
// One cell of the square-root chain: decides one root bit and hands its state on.
// Depends on tgje_pkg. The chain of cells finds the largest root r with DIV_FACTOR * r * r <= sum.
module tgje_sqrt_cell #(
	parameter int VALUE_BITS = tgje_pkg::VALUE_BITS_DEF,
	parameter int BIT        = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      up_valid,
	input  logic [2*VALUE_BITS+2:0]   up_rem,
	input  logic [VALUE_BITS:0]       up_root,
	input  logic [VALUE_BITS+3:0]     up_six,
	output logic                      valid,
	output logic [2*VALUE_BITS+2:0]   rem,
	output logic [VALUE_BITS:0]       root,
	output logic [VALUE_BITS+3:0]     six_root
);
	localparam int RW = 2 * VALUE_BITS + 3;
	localparam int TW = RW + 1;
	localparam int KW = VALUE_BITS + 4;
	localparam int QW = VALUE_BITS + 1;

	logic [KW-1:0] base;
	logic [TW-1:0] trial;
	logic [TW-1:0] diff;
	logic          fits;

	// With r6 = 6 * root so far, setting this bit costs 3 * (2 * root + 2^BIT) * 2^BIT.
	// Root bits above BIT make r6 a multiple of 2^(BIT+2), so the OR is an exact add.
	assign base  = up_six | (KW'(tgje_pkg::DIV_FACTOR) << BIT);
	assign trial = TW'(base) << BIT;
	assign diff  = {1'b0, up_rem} - trial;
	assign fits  = {1'b0, up_rem} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (en) begin
			valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem      <= fits ? diff[RW-1:0] : up_rem;
			root     <= up_root | (QW'(fits) << BIT);
			six_root <= fits ? up_six + (KW'(2 * tgje_pkg::DIV_FACTOR) << BIT) : up_six;
		end
	end

endmodule

@@ sv/triangle_gradient_jump_error_top.sv @@
// An accepted triangle passes five front stages, one square-root cell per root bit and
// one output register, in that order, before it reaches the result.
// Throughput: one triangle per cycle; the whole pipeline stalls only while the skid entry is full.
// The chain of VALUE_BITS+1 root cells sets the depth. Reset clears all valid bits at once;
// data registers are not reset. Depends on tgje_pkg, tgje_in_if, tgje_out_if and the submodules.
module triangle_gradient_jump_error_top #(
	parameter int VALUE_BITS = tgje_pkg::VALUE_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tgje_in_if.sink   vertices,
	tgje_out_if.source result
);
	localparam int NC = VALUE_BITS + 1;
	localparam int RW = 2 * VALUE_BITS + 3;
	localparam int TW = RW + 1;
	localparam int KW = VALUE_BITS + 4;
	localparam int QW = VALUE_BITS + 1;

	logic          en;
	logic          valid_c [NC+1];
	logic [RW-1:0] rem_c   [NC+1];
	logic [QW-1:0] root_c  [NC+1];
	logic [KW-1:0] six_c   [NC+1];

	logic          out_valid_q;
	logic [QW-1:0] out_data_q;
	logic          skid_valid_q;
	logic [QW-1:0] skid_data_q;
	logic          push;
	logic          pop;

	// The pipeline moves whenever the skid entry is free, so ready depends on a register only.
	assign en             = !skid_valid_q;
	assign vertices.ready = en;

	tgje_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (vertices.valid),
		.ax       (vertices.ax),
		.ay       (vertices.ay),
		.bx       (vertices.bx),
		.by_coord (vertices.by_coord),
		.cx       (vertices.cx),
		.cy       (vertices.cy),
		.ga_x     (vertices.ga_x),
		.ga_y     (vertices.ga_y),
		.gb_x     (vertices.gb_x),
		.gb_y     (vertices.gb_y),
		.gc_x     (vertices.gc_x),
		.gc_y     (vertices.gc_y),
		.sum_valid(valid_c[0]),
		.sum      (rem_c[0])
	);

	assign root_c[0] = '0;
	assign six_c[0]  = '0;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		tgje_sqrt_cell #(
			.VALUE_BITS(VALUE_BITS),
			.BIT       (VALUE_BITS - i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.up_valid(valid_c[i]),
			.up_rem  (rem_c[i]),
			.up_root (root_c[i]),
			.up_six  (six_c[i]),
			.valid   (valid_c[i+1]),
			.rem     (rem_c[i+1]),
			.root    (root_c[i+1]),
			.six_root(six_c[i+1])
		);
	end

	assign push = en && valid_c[NC];
	assign pop  = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= root_c[NC];
			end
		end else if (push) begin
			skid_data_q <= root_c[NC];
		end
	end

	assign result.valid         = out_valid_q;
	assign result.element_error = out_data_q;

	// The chain must leave 6 * root in its running term.
	a_six_root: assert property (@(posedge clk) disable iff (!arst_n)
		valid_c[NC] |-> six_c[NC] == (KW'(root_c[NC]) << 2) + (KW'(root_c[NC]) << 1))
		else $error("root chain lost track of six times the root");

	// The remainder must be too small for the next larger root.
	a_root_max: assert property (@(posedge clk) disable iff (!arst_n)
		valid_c[NC] |-> TW'(rem_c[NC]) < TW'(six_c[NC]) + TW'(tgje_pkg::DIV_FACTOR))
		else $error("root is not the largest one that fits");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a beat while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(result.valid && !result.ready))
		else $error("skid entry filled without a stalled output");

endmodule

@@ dv/tgje_error_monitor.sv @@
// Watches both channels of the triangle error block, predicts each result and compares it.
// Depends on tgje_pkg, tgje_in_if and tgje_out_if; hands failure and backlog counts to the top.
`timescale 1ns / 100ps

module tgje_error_monitor #(
	parameter int VALUE_BITS = tgje_pkg::VALUE_BITS_DEF
) (
	input logic  clk,
	input logic  arst_n,
	tgje_in_if   vertices,
	tgje_out_if  result,
	output int   mismatches,
	output int   pending
);

	typedef logic signed [VALUE_BITS-1:0] coord_t;
	typedef logic [VALUE_BITS:0] error_t;

	typedef struct {
		coord_t ax, ay, bx, by_coord, cx, cy;
		coord_t ga_x, ga_y, gb_x, gb_y, gc_x, gc_y;
	} triangle_t;

	error_t expected_errors[$];
	int fail_count;

	// Absolute jump of the gradient along one edge, exact in 64 bits.
	function automatic longint edge_jump(longint p0x, longint p0y, longint p1x, longint p1y,
			longint g0x, longint g0y, longint g1x, longint g1y);
		longint dot;
		dot = (p1x - p0x) * (g1x - g0x) + (p1y - p0y) * (g1y - g0y);
		return (dot < 0) ? -dot : dot;
	endfunction

	function automatic error_t error_estimate(triangle_t t);
		longint total;
		longint quotient;
		longint root;
		longint cand;
		total = edge_jump(t.ax, t.ay, t.bx, t.by_coord, t.ga_x, t.ga_y, t.gb_x, t.gb_y)
			+ edge_jump(t.bx, t.by_coord, t.cx, t.cy, t.gb_x, t.gb_y, t.gc_x, t.gc_y)
			+ edge_jump(t.cx, t.cy, t.ax, t.ay, t.gc_x, t.gc_y, t.ga_x, t.ga_y);
		quotient = total / tgje_pkg::DIV_FACTOR;
		root = 0;
		// Floor square root, one bit at a time from the top.
		for (int b = VALUE_BITS; b >= 0; b--) begin
			cand = root | (64'sd1 << b);
			if (cand * cand <= quotient)
				root = cand;
		end
		return error_t'(root);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		triangle_t tri_in;
		error_t want;
		if (!arst_n) begin
			expected_errors.delete();
			fail_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (vertices.valid && vertices.ready) begin
				tri_in.ax = vertices.ax;
				tri_in.ay = vertices.ay;
				tri_in.bx = vertices.bx;
				tri_in.by_coord = vertices.by_coord;
				tri_in.cx = vertices.cx;
				tri_in.cy = vertices.cy;
				tri_in.ga_x = vertices.ga_x;
				tri_in.ga_y = vertices.ga_y;
				tri_in.gb_x = vertices.gb_x;
				tri_in.gb_y = vertices.gb_y;
				tri_in.gc_x = vertices.gc_x;
				tri_in.gc_y = vertices.gc_y;
				expected_errors.push_back(error_estimate(tri_in));
			end
			if (result.valid && result.ready) begin
				if (expected_errors.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with none expected, element_error %0d",
							$realtime, result.element_error);
				end else begin
					want = expected_errors.pop_front();
					if (result.element_error !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: element_error expected %0d, got %0d",
								$realtime, want, result.element_error);
					end
				end
			end
			mismatches <= fail_count;
			pending <= expected_errors.size();
		end
	end

endmodule

@@ dv/triangle_gradient_jump_error_top_tb.sv @@
// Top of the testbench for the triangle error block: clock, reset, stimulus and verdict.
// Depends on tgje_pkg, both channel interfaces, the block and tgje_error_monitor.
`timescale 1ns / 100ps

module triangle_gradient_jump_error_top_tb;

	localparam int VB = tgje_pkg::VALUE_BITS_DEF;
	localparam int LATENCY = VB + 7;
	localparam int RANDOM_ITEMS = 1500;

	typedef logic signed [VB-1:0] value_t;
	typedef enum int {AX, AY, BX, BY, CX, CY, GAX, GAY, GBX, GBY, GCX, GCY, NUM_FIELDS} field_e;
	typedef value_t triangle_vals_t [NUM_FIELDS];

	localparam value_t VMAX = {1'b0, {(VB-1){1'b1}}};
	localparam value_t VMIN = {1'b1, {(VB-1){1'b0}}};

	logic clk;
	logic arst_n;
	int items_sent;
	bit steady;
	int mismatches;
	int pending;

	tgje_in_if #(.VALUE_BITS(VB)) vertices_if ();
	tgje_out_if #(.VALUE_BITS(VB)) result_if ();

	triangle_gradient_jump_error_top #(.VALUE_BITS(VB)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.vertices (vertices_if),
		.result   (result_if)
	);

	tgje_error_monitor #(.VALUE_BITS(VB)) error_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.vertices   (vertices_if),
		.result     (result_if),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic value_t span_value(int half);
		return value_t'(int'($urandom_range(0, 2 * half)) - half);
	endfunction

	function automatic value_t edge_value();
		case ($urandom_range(0, 5))
			0: return VMIN;
			1: return VMAX;
			2: return value_t'(0);
			3: return value_t'(-1);
			4: return value_t'(1);
			default: return value_t'($urandom);
		endcase
	endfunction

	function automatic triangle_vals_t random_triangle();
		triangle_vals_t f;
		value_t dx;
		value_t dy;
		foreach (f[i]) f[i] = value_t'($urandom);
		case ($urandom_range(0, 9))
			4: begin
				foreach (f[i]) f[i] = span_value(8);
			end
			5: begin
				foreach (f[i]) f[i] = edge_value();
			end
			6: begin
				// Degenerate: two or three vertices coincide.
				f[BX] = f[AX];
				f[BY] = f[AY];
				if ($urandom_range(0, 1)) begin
					f[CX] = f[AX];
					f[CY] = f[AY];
				end
			end
			7: begin
				f[GBX] = f[GAX];
				f[GBY] = f[GAY];
				f[GCX] = f[GAX];
				f[GCY] = f[GAY];
			end
			8: begin
				// Collinear vertices, kept small enough that nothing wraps.
				f[AX] = span_value(1 << 21);
				f[AY] = span_value(1 << 21);
				dx = span_value(1 << 20);
				dy = span_value(1 << 20);
				f[BX] = f[AX] + dx;
				f[BY] = f[AY] + dy;
				f[CX] = f[AX] + dx + dx;
				f[CY] = f[AY] + dy + dy;
			end
			9: begin
				for (int i = GAX; i <= GCY; i++) f[i] = span_value(1 << 10);
			end
			default: ;
		endcase
		return f;
	endfunction

	task automatic send_triangle(input triangle_vals_t f);
		int gap;
		vertices_if.ax <= f[AX];
		vertices_if.ay <= f[AY];
		vertices_if.bx <= f[BX];
		vertices_if.by_coord <= f[BY];
		vertices_if.cx <= f[CX];
		vertices_if.cy <= f[CY];
		vertices_if.ga_x <= f[GAX];
		vertices_if.ga_y <= f[GAY];
		vertices_if.gb_x <= f[GBX];
		vertices_if.gb_y <= f[GBY];
		vertices_if.gc_x <= f[GCX];
		vertices_if.gc_y <= f[GCY];
		vertices_if.valid <= 1'b1;
		do @(posedge clk); while (!vertices_if.ready);
		items_sent++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			vertices_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result side: random stalls, one long hold-off to back the pipeline up into the input.
	initial begin
		int run;
		int stall;
		bit held_off;
		result_if.ready = 1'b0;
		held_off = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && items_sent >= 300) begin
				held_off = 1'b1;
				result_if.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 10);
			repeat (run) @(posedge clk);
			stall = steady ? 0 : pick_gap();
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		triangle_vals_t f;
		triangle_vals_t m;
		items_sent = 0;
		steady = 1'b0;
		vertices_if.valid = 1'b0;
		vertices_if.ax = '0;
		vertices_if.ay = '0;
		vertices_if.bx = '0;
		vertices_if.by_coord = '0;
		vertices_if.cx = '0;
		vertices_if.cy = '0;
		vertices_if.ga_x = '0;
		vertices_if.ga_y = '0;
		vertices_if.gb_x = '0;
		vertices_if.gb_y = '0;
		vertices_if.gc_x = '0;
		vertices_if.gc_y = '0;
		wait (arst_n);
		@(posedge clk);

		// Directed triangles, each sent as given and then with the winding reversed.
		for (int k = 0; k < 12; k++) begin
			foreach (f[i]) f[i] = '0;
			case (k)
				1: foreach (f[i]) f[i] = VMAX;
				2: foreach (f[i]) f[i] = VMIN;
				3, 4: begin
					f[AX] = VMIN;
					f[AY] = VMIN;
					f[BX] = VMAX;
					f[BY] = VMAX;
					f[CX] = VMIN;
					f[CY] = VMAX;
					for (int i = 0; i < 6; i++)
						f[GAX + i] = (k == 3) ? f[i] : ~f[i];
				end
				5: begin
					foreach (f[i]) f[i] = value_t'($urandom);
					f[GBX] = f[GAX];
					f[GBY] = f[GAY];
					f[GCX] = f[GAX];
					f[GCY] = f[GAY];
				end
				6: begin
					foreach (f[i]) f[i] = value_t'($urandom);
					f[BX] = f[AX];
					f[BY] = f[AY];
					f[CX] = f[AX];
					f[CY] = f[AY];
				end
				7: begin
					// Edge sum of four: the smallest nonzero root.
					f[BX] = value_t'(1);
					f[CY] = value_t'(1);
					f[GBX] = value_t'(1);
					f[GCY] = value_t'(1);
				end
				8: begin
					// Edge sum of two, which floors to zero after the division.
					f[BX] = value_t'(1);
					f[GBX] = value_t'(1);
				end
				9: begin
					// The two products of one edge cancel exactly.
					f[BX] = VMAX;
					f[BY] = VMAX;
					f[GBX] = VMAX;
					f[GBY] = -VMAX;
				end
				10: begin
					f[AX] = value_t'(-1);
					f[AY] = value_t'(-1);
					f[BX] = value_t'(1);
					f[BY] = value_t'(1);
					f[CX] = value_t'(-1);
					f[CY] = value_t'(1);
					f[GAX] = value_t'(1);
					f[GAY] = value_t'(1);
					f[GBX] = value_t'(-1);
					f[GBY] = value_t'(-1);
					f[GCX] = value_t'(1);
					f[GCY] = value_t'(-1);
				end
				11: foreach (f[i]) f[i] = edge_value();
				default: ;
			endcase
			send_triangle(f);
			m = f;
			m[BX] = f[CX];
			m[BY] = f[CY];
			m[CX] = f[BX];
			m[CY] = f[BY];
			m[GBX] = f[GCX];
			m[GBY] = f[GCY];
			m[GCX] = f[GBX];
			m[GCY] = f[GBY];
			send_triangle(m);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// A window with no idling on either side.
			steady = (n >= 700 && n < 850);
			send_triangle(random_triangle());
		end
		steady = 1'b0;
		vertices_if.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
